### rtl/rmv_pkg.sv
// shared types for the running mean and variance block
package rmv_pkg;

    // fixed output field widths and the sum register width
    localparam int VAR_BITS = 48;
    localparam int SD_BITS  = 32;
    localparam int SUM_BITS = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_MEAN,
        ST_MEAN_UPD,
        ST_MUL,
        ST_SUM_UPD,
        ST_VAR_CHK,
        ST_DIV_VAR,
        ST_VAR_UPD,
        ST_SQRT,
        ST_SD_UPD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic mean_upd;
        logic mul_step;
        logic sum_upd;
        logic var_start;
        logic var_upd;
        logic sq_step;
        logic sd_upd;
        logic var_zero;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic unit_done;
        logic two_plus;
    } status_t;

endpackage

### rtl/rmv_ctrl.sv
// sequencer for the running mean and variance block
module rmv_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  rmv_pkg::status_t sts,
    output rmv_pkg::cmd_t    cmd
);

    rmv_pkg::state_t state_reg;
    rmv_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmv_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            rmv_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.skip ? rmv_pkg::ST_VAR_CHK : rmv_pkg::ST_DIV_MEAN;
                end
            end
            rmv_pkg::ST_DIV_MEAN:
            begin
                if (sts.unit_done)
                    state_next = rmv_pkg::ST_MEAN_UPD;
                else
                    cmd.div_step = 1'b1;
            end
            rmv_pkg::ST_MEAN_UPD:
            begin
                cmd.mean_upd = 1'b1;
                state_next   = rmv_pkg::ST_MUL;
            end
            rmv_pkg::ST_MUL:
            begin
                if (sts.unit_done)
                    state_next = rmv_pkg::ST_SUM_UPD;
                else
                    cmd.mul_step = 1'b1;
            end
            rmv_pkg::ST_SUM_UPD:
            begin
                cmd.sum_upd = 1'b1;
                state_next  = rmv_pkg::ST_VAR_CHK;
            end
            rmv_pkg::ST_VAR_CHK:
            begin
                if (sts.two_plus)
                begin
                    cmd.var_start = 1'b1;
                    state_next    = rmv_pkg::ST_DIV_VAR;
                end
                else
                begin
                    cmd.var_zero = 1'b1;
                    state_next   = rmv_pkg::ST_DONE;
                end
            end
            rmv_pkg::ST_DIV_VAR:
            begin
                if (sts.unit_done)
                    state_next = rmv_pkg::ST_VAR_UPD;
                else
                    cmd.div_step = 1'b1;
            end
            rmv_pkg::ST_VAR_UPD:
            begin
                cmd.var_upd = 1'b1;
                state_next  = rmv_pkg::ST_SQRT;
            end
            rmv_pkg::ST_SQRT:
            begin
                if (sts.unit_done)
                    state_next = rmv_pkg::ST_SD_UPD;
                else
                    cmd.sq_step = 1'b1;
            end
            rmv_pkg::ST_SD_UPD:
            begin
                cmd.sd_upd = 1'b1;
                state_next = rmv_pkg::ST_DONE;
            end
            rmv_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = rmv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/rmv_dp.sv
// statistics registers, serial divider, multiplier and square root
module rmv_dp #(
    parameter int SAMPLE_BITS = 32,
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rmv_pkg::cmd_t                   cmd,
    output rmv_pkg::status_t                sts,
    input  logic signed [SAMPLE_BITS-1:0]   sample,
    input  logic                            sample_invalid,
    output logic [COUNT_BITS-1:0]           sample_count,
    output logic signed [SAMPLE_BITS-1:0]   minimum,
    output logic signed [SAMPLE_BITS-1:0]   maximum,
    output logic signed [SAMPLE_BITS-1:0]   mean_value,
    output logic [rmv_pkg::VAR_BITS-1:0]    variance,
    output logic [rmv_pkg::SD_BITS-1:0]     std_dev
);

    localparam int XB   = (SAMPLE_BITS <= 46) ? 16 : (62 - SAMPLE_BITS);
    localparam int MW   = SAMPLE_BITS + XB;
    localparam int DW   = MW + 1;
    localparam int PW   = 2 * MW;
    localparam int PS   = FRAC_BITS + 2 * XB;
    localparam int SW   = rmv_pkg::SUM_BITS;
    localparam int EW   = PW + SW;
    localparam int VW   = rmv_pkg::VAR_BITS;
    localparam int SDW  = rmv_pkg::SD_BITS;
    localparam int RW   = (VW + FRAC_BITS + 1) / 2;
    localparam int OPW  = 2 * RW;
    localparam int RXW  = RW + SDW;
    localparam int CNTW = 7;

    localparam logic [CNTW-1:0] DIV_STEPS = CNTW'(SW);
    localparam logic [CNTW-1:0] MUL_STEPS = CNTW'(MW);
    localparam logic [CNTW-1:0] SQ_STEPS  = CNTW'(RW);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // running state
    logic [COUNT_BITS-1:0]  count_reg;
    logic [SAMPLE_BITS-1:0] min_reg;
    logic [SAMPLE_BITS-1:0] max_reg;
    logic [MW-1:0]          mean_reg;
    logic [SW-1:0]          sum_reg;

    // per item working registers
    logic [MW-1:0]          xe_reg;
    logic                   dneg_reg;
    logic [MW-1:0]          dmag_reg;
    logic [CNTW-1:0]        cnt_reg;
    logic [COUNT_BITS:0]    rem_reg;
    logic [SW-1:0]          quo_reg;
    logic [COUNT_BITS-1:0]  dvs_reg;
    logic [PW-1:0]          mula_reg;
    logic [MW-1:0]          mulb_reg;
    logic [PW-1:0]          prod_reg;
    logic [OPW-1:0]         sqop_reg;
    logic [RW:0]            sqrem_reg;
    logic [RW-1:0]          root_reg;
    logic [VW-1:0]          var_reg;
    logic [SDW-1:0]         sd_reg;

    // output beat registers
    logic [COUNT_BITS-1:0]  cnt_out_reg;
    logic [SAMPLE_BITS-1:0] min_out_reg;
    logic [SAMPLE_BITS-1:0] max_out_reg;
    logic [SAMPLE_BITS-1:0] mean_out_reg;
    logic [VW-1:0]          var_out_reg;
    logic [SDW-1:0]         sd_out_reg;

    logic [COUNT_BITS-1:0]  count_inc;
    logic [MW-1:0]          xe;
    logic [DW-1:0]          delta;
    logic [DW-1:0]          dmag_full;
    logic [MW-1:0]          mean_new;
    logic [DW-1:0]          d2;
    logic [DW-1:0]          d2mag;
    logic [COUNT_BITS:0]    div_sh;
    logic                   div_bit;
    logic [EW-1:0]          prod_ext;
    logic [SW:0]            sum_add;
    logic [RW+2:0]          sq_sh;
    logic [RW+2:0]          sq_trial;
    logic                   sq_bit;
    logic [RXW-1:0]         root_ext;

    assign count_inc = (count_reg == CMAX) ? count_reg : count_reg + 1'b1;
    assign xe        = {sample, {XB{1'b0}}};
    assign delta     = {xe[MW-1], xe} - {mean_reg[MW-1], mean_reg};
    assign dmag_full = delta[DW-1] ? (~delta + 1'b1) : delta;

    assign mean_new  = dneg_reg ? (mean_reg - quo_reg[MW-1:0]) : (mean_reg + quo_reg[MW-1:0]);
    assign d2        = {xe_reg[MW-1], xe_reg} - {mean_new[MW-1], mean_new};
    assign d2mag     = d2[DW-1] ? (~d2 + 1'b1) : d2;

    assign div_sh    = {rem_reg[COUNT_BITS-1:0], quo_reg[SW-1]};
    assign div_bit   = (div_sh >= {1'b0, dvs_reg});

    assign prod_ext  = EW'(prod_reg) >> PS;
    assign sum_add   = {1'b0, sum_reg} + {1'b0, prod_ext[SW-1:0]};

    assign sq_sh     = {sqrem_reg, sqop_reg[OPW-1:OPW-2]};
    assign sq_trial  = {1'b0, root_reg, 2'b01};
    assign sq_bit    = (sq_sh >= sq_trial);
    assign root_ext  = RXW'(root_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= SMAX;
            max_reg   <= SMIN;
            mean_reg  <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.accept && !sample_invalid)
            begin
                count_reg <= count_inc;
                if ($signed(sample) > $signed(max_reg))
                    max_reg <= sample;
                if ($signed(sample) < $signed(min_reg))
                    min_reg <= sample;
                cnt_reg <= DIV_STEPS;
            end
            if (cmd.mean_upd)
            begin
                mean_reg <= mean_new;
                cnt_reg  <= MUL_STEPS;
            end
            if (cmd.sum_upd)
            begin
                if ((|(prod_ext >> SW)) || sum_add[SW])
                    sum_reg <= '1;
                else
                    sum_reg <= sum_add[SW-1:0];
            end
            if (cmd.var_start)
                cnt_reg <= DIV_STEPS;
            if (cmd.var_upd)
                cnt_reg <= SQ_STEPS;
            if (cmd.div_step || cmd.mul_step || cmd.sq_step)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            xe_reg   <= xe;
            dneg_reg <= delta[DW-1];
            dmag_reg <= dmag_full[MW-1:0];
            rem_reg  <= '0;
            quo_reg  <= SW'(dmag_full[MW-1:0]);
            dvs_reg  <= count_inc;
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_bit ? (div_sh - {1'b0, dvs_reg}) : div_sh;
            quo_reg <= {quo_reg[SW-2:0], div_bit};
        end
        if (cmd.mean_upd)
        begin
            mula_reg <= PW'(dmag_reg);
            mulb_reg <= d2mag[MW-1:0];
            prod_reg <= '0;
        end
        if (cmd.mul_step)
        begin
            if (mulb_reg[0])
                prod_reg <= prod_reg + mula_reg;
            mula_reg <= {mula_reg[PW-2:0], 1'b0};
            mulb_reg <= {1'b0, mulb_reg[MW-1:1]};
        end
        if (cmd.var_start)
        begin
            rem_reg <= '0;
            quo_reg <= sum_reg;
            dvs_reg <= count_reg - 1'b1;
        end
        if (cmd.var_upd)
        begin
            var_reg   <= (|(quo_reg >> VW)) ? '1 : quo_reg[VW-1:0];
            sqop_reg  <= (|(quo_reg >> VW)) ? (OPW'({VW{1'b1}}) << FRAC_BITS)
                                           : (OPW'(quo_reg[VW-1:0]) << FRAC_BITS);
            sqrem_reg <= '0;
            root_reg  <= '0;
        end
        if (cmd.sq_step)
        begin
            sqrem_reg <= sq_bit ? (RW+1)'(sq_sh - sq_trial) : (RW+1)'(sq_sh);
            root_reg  <= {root_reg[RW-2:0], sq_bit};
            sqop_reg  <= {sqop_reg[OPW-3:0], 2'b00};
        end
        if (cmd.sd_upd)
            sd_reg <= (|(root_ext >> SDW)) ? '1 : root_ext[SDW-1:0];
        if (cmd.var_zero)
        begin
            var_reg <= '0;
            sd_reg  <= '0;
        end
        if (cmd.out_load)
        begin
            cnt_out_reg  <= count_reg;
            min_out_reg  <= (count_reg != '0) ? min_reg : SMIN;
            max_out_reg  <= (count_reg != '0) ? max_reg : SMAX;
            mean_out_reg <= mean_reg[MW-1:XB];
            var_out_reg  <= var_reg;
            sd_out_reg   <= sd_reg;
        end
    end

    assign sts.skip      = sample_invalid;
    assign sts.unit_done = (cnt_reg == '0);
    assign sts.two_plus  = (count_reg > COUNT_BITS'(1));

    assign sample_count = cnt_out_reg;
    assign minimum      = min_out_reg;
    assign maximum      = max_out_reg;
    assign mean_value   = mean_out_reg;
    assign variance     = var_out_reg;
    assign std_dev      = sd_out_reg;

endmodule

### rtl/running_mean_variance_core.sv
// top level of the running mean and variance block
// usage:
//   input channel: one beat carries a signed fixed-point sample and an invalid
//   flag; it is taken when in_valid is high and in_stall is low. a flagged
//   sample leaves the statistics untouched but still yields one result beat.
//   output channel: one beat per input beat with count, min, max, mean,
//   sample variance and standard deviation, taken when out_valid is high and
//   out_stall is low; the result register holds steady while stalled.
// sequencing:
//   one beat in flight at a time. a valid sample goes through the bit-serial
//   divider used twice (mean step and variance), the bit-serial multiplier
//   and the two-bit-per-cycle square root.
//   a flagged sample skips the mean divide and the multiply.
//   below two samples the variance divide and root are skipped.
//   in_stall is low only while the sequencer idles; a finished beat waiting
//   in the output register does not block the next input beat, but the
//   sequencer waits at its end until that register frees up.
// reset: count, mean and sum clear, min/max go to their empty values,
//   out_valid drops.
module running_mean_variance_core #(
    parameter int SAMPLE_BITS = 32,
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          sample_invalid,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [COUNT_BITS-1:0]         sample_count,
    output logic signed [SAMPLE_BITS-1:0] minimum,
    output logic signed [SAMPLE_BITS-1:0] maximum,
    output logic signed [SAMPLE_BITS-1:0] mean_value,
    output logic [rmv_pkg::VAR_BITS-1:0]  variance,
    output logic [rmv_pkg::SD_BITS-1:0]   std_dev
);

    // command and status between sequencer and datapath
    rmv_pkg::cmd_t    cmd;
    rmv_pkg::status_t sts;

    rmv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    rmv_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .sample         (sample),
        .sample_invalid (sample_invalid),
        .sample_count   (sample_count),
        .minimum        (minimum),
        .maximum        (maximum),
        .mean_value     (mean_value),
        .variance       (variance),
        .std_dev        (std_dev)
    );

endmodule
